>>> rtl/pdc_pkg.sv
`default_nettype none

package pdc_pkg;

   // frame layout and crc constants
   localparam int COUNT_WIDTH = 16;
   localparam int HDR_LEN = 9;
   localparam int MIN_LEN = 11;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // frame status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SHORT  = 2'd1,
      STATUS_CRC    = 2'd2,
      STATUS_LENGTH = 2'd3
   } status_type;

   // one result word
   typedef struct packed {
      logic [7:0]  echo_byte;
      logic        is_payload;
      logic        done_res;
      status_type  status;
      logic [7:0]  version;
      logic [15:0] message_id;
      logic [7:0]  stream_id;
      logic [15:0] fragment_index;
      logic [15:0] fragment_total;
      logic [7:0]  payload_length;
   } result_type;

   // crc-16 ccitt byte update, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/pdc_frame_state.sv
`default_nettype none

module pdc_frame_state (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          in_byte,
   input  wire logic                frame_end,
   output pdc_pkg::result_type      result
);

   localparam int CW = pdc_pkg::COUNT_WIDTH;

   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    held0_ff, held0_in;
   logic [7:0]    held1_ff, held1_in;
   logic [7:0]    hdr_ff [pdc_pkg::HDR_LEN];
   logic [7:0]    hdr_in [pdc_pkg::HDR_LEN];

   logic [CW-1:0] total;
   logic [CW-1:0] expect_len;
   logic [CW-1:0] pay_off;
   logic [15:0]   crc_upd;
   logic          count_full;

   // crc runs two bytes behind the input
   always_comb begin
      count_full = &count_ff;
      crc_upd = (|count_ff[CW-1:1]) ? pdc_pkg::crc_byte(crc_ff, held0_ff) : crc_ff;
   end

   // header capture including the current word
   always_comb begin
      for (int k = 0; k < pdc_pkg::HDR_LEN; k++) begin
         hdr_in[k] = (count_ff == CW'(k)) ? in_byte : hdr_ff[k];
      end
   end

   // result word
   always_comb begin
      total = count_full ? count_ff : count_ff + CW'(1);
      expect_len = CW'(pdc_pkg::MIN_LEN) + {{(CW-8){1'b0}}, hdr_in[8]};
      pay_off = count_ff - CW'(pdc_pkg::HDR_LEN);
      result = '0;
      result.echo_byte = in_byte;
      result.is_payload = (count_ff >= CW'(pdc_pkg::HDR_LEN)) &&
                          (pay_off < {{(CW-8){1'b0}}, hdr_ff[8]});
      result.done_res = frame_end;
      if (frame_end) begin
         priority if (total < CW'(pdc_pkg::MIN_LEN)) begin
            result.status = pdc_pkg::STATUS_SHORT;
         end else if (crc_upd != {in_byte, held1_ff}) begin
            result.status = pdc_pkg::STATUS_CRC;
         end else if (total != expect_len) begin
            result.status = pdc_pkg::STATUS_LENGTH;
         end else begin
            result.status = pdc_pkg::STATUS_OK;
         end
         result.version = hdr_in[0];
         result.message_id = {hdr_in[2], hdr_in[1]};
         result.stream_id = hdr_in[3];
         result.fragment_index = {hdr_in[5], hdr_in[4]};
         result.fragment_total = {hdr_in[7], hdr_in[6]};
         result.payload_length = hdr_in[8];
      end
   end

   // next frame state
   always_comb begin
      count_in = count_full ? count_ff : count_ff + CW'(1);
      crc_in = crc_upd;
      held0_in = held1_ff;
      held1_in = in_byte;
   end

   // frame state registers, cleared after the last word
   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         count_ff <= '0;
         crc_ff <= pdc_pkg::CRC_INIT;
         held0_ff <= '0;
         held1_ff <= '0;
         for (int k = 0; k < pdc_pkg::HDR_LEN; k++) begin
            hdr_ff[k] <= '0;
         end
      end else if (step) begin
         count_ff <= count_in;
         crc_ff <= crc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         for (int k = 0; k < pdc_pkg::HDR_LEN; k++) begin
            hdr_ff[k] <= hdr_in[k];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/packet_deframer_crc16_check.sv
// a word accepted on req is held in the input register, passes into the result register
// when rsp is not stalled, and is presented on rsp from there
// throughput: one word per cycle when rsp is not stalled, set by the single-pass crc
// and check logic between the input register and the result register
// reset (synchronous, active high) empties both registers and returns the frame
// state to its start: count zero, crc 0xffff, held bytes and header zero
`default_nettype none

module packet_deframer_crc16_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_frame_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_echo_byte,
   output logic             rsp_is_payload,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_version,
   output logic [15:0]      rsp_message_id,
   output logic [7:0]       rsp_stream_id,
   output logic [15:0]      rsp_fragment_index,
   output logic [15:0]      rsp_fragment_total,
   output logic [7:0]       rsp_payload_length
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_end_ff;
   logic                out_valid_ff, out_valid_in;
   pdc_pkg::result_type out_ff;
   pdc_pkg::result_type result;
   logic                out_open;
   logic                step;
   logic                req_take;

   // handshake
   always_comb begin
      out_open = !out_valid_ff || !rsp_stall;
      step = in_valid_ff && out_open;
      req_stall = in_valid_ff && !out_open;
      req_take = req_valid && !req_stall;
      in_valid_in = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      out_valid_in = out_open ? in_valid_ff : out_valid_ff;
   end

   // frame checker
   pdc_frame_state u_state (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .frame_end (in_end_ff),
      .result    (result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_end_ff <= req_frame_end;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   // result ports
   always_comb begin
      rsp_valid = out_valid_ff;
      rsp_echo_byte = out_ff.echo_byte;
      rsp_is_payload = out_ff.is_payload;
      rsp_done_res = out_ff.done_res;
      rsp_status = out_ff.status;
      rsp_version = out_ff.version;
      rsp_message_id = out_ff.message_id;
      rsp_stream_id = out_ff.stream_id;
      rsp_fragment_index = out_ff.fragment_index;
      rsp_fragment_total = out_ff.fragment_total;
      rsp_payload_length = out_ff.payload_length;
   end

endmodule

`default_nettype wire
